### rtl/core/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Shared types and constants for the animation ring sequencer.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int QSLOTS      = 16;
  localparam int IDX_W       = $clog2(QSLOTS);
  localparam int FRAME_COUNT = 8;
  localparam int NODE_W      = 8;
  localparam int FRAME_W     = 6;
  localparam int OUT_FRAME_W = 3;
  localparam int DELAY_W     = 4;
  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(4);

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic add;    // enqueue the node of the current transaction
    logic start;  // latch head/tail for a new walk
    logic step;   // visit and advance one entry
    logic flush;  // push the held result out, marked last
  } ars_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic step_ok;
    logic pend_valid;
    logic can_push;
  } ars_sts_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == IDX_W'(QSLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

### rtl/core/ars_ctrl.sv
// ----------------------------------------------------------------------------
// ars_ctrl
// Sequencer for the ring walk: accepts requests, steps entries, flushes.
// ----------------------------------------------------------------------------
module ars_ctrl
  import ars_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  ars_sts_t sts,
  output ars_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_t'(in_req_type) == REQ_TICK) begin
            cmd.start = 1'b1;
            state_nxt = ST_WALK;
          end else begin
            cmd.add = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ST_FLUSH;
        end else if (sts.step_ok) begin
          cmd.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        // hold until the last result can enter the output register
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.can_push) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ars_dpath.sv
// ----------------------------------------------------------------------------
// ars_dpath
// Entry storage, ring pointers, one-result lookahead and output register.
// ----------------------------------------------------------------------------
module ars_dpath
  import ars_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ars_cmd_t               cmd,
  output ars_sts_t               sts,
  input  logic [NODE_W-1:0]      in_node_id,
  input  logic                   cfg_wr_en,
  input  logic [DELAY_W-1:0]     cfg_wr_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NODE_W-1:0]      out_node_id_res,
  output logic [OUT_FRAME_W-1:0] out_frame,
  output logic                   out_last
);

  logic [NODE_W-1:0]  entry_node_r   [QSLOTS];
  logic [FRAME_W-1:0] entry_frame_r  [QSLOTS];
  logic               entry_toggle_r [QSLOTS];

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [IDX_W-1:0]   walk_r, walk_nxt;
  logic [IDX_W-1:0]   end_r,  end_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;

  logic                   pend_valid_r, pend_valid_nxt;
  logic [NODE_W-1:0]      pend_node_r, pend_node_nxt;
  logic [OUT_FRAME_W-1:0] pend_frame_r, pend_frame_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]      out_node_r, out_node_nxt;
  logic [OUT_FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [NODE_W-1:0]  cur_node;
  logic [FRAME_W-1:0] cur_frame;
  logic               cur_toggle;
  logic [FRAME_W-1:0] inc_frame;
  logic               emit;
  logic               retire;
  logic               can_push;
  logic               q_full;
  logic               add_ok;
  logic               push;
  logic               push_last;

  assign cur_node   = entry_node_r[walk_r];
  assign cur_frame  = entry_frame_r[walk_r];
  assign cur_toggle = entry_toggle_r[walk_r];
  assign inc_frame  = cur_frame + 1'b1;
  assign emit       = !cur_frame[FRAME_W-1];
  assign retire     = cur_toggle && !inc_frame[FRAME_W-1] &&
                      (inc_frame[FRAME_W-2:0] >= (FRAME_W-1)'(FRAME_COUNT));
  assign can_push   = !out_valid_r || out_ready;
  assign q_full     = (next_slot(tail_r) == head_r);
  assign add_ok     = cmd.add && !q_full;
  assign push       = (cmd.step && emit && pend_valid_r) || cmd.flush;
  assign push_last  = cmd.flush;

  assign sts.walk_done  = (walk_r == end_r);
  assign sts.step_ok    = !(emit && pend_valid_r) || can_push;
  assign sts.pend_valid = pend_valid_r;
  assign sts.can_push   = can_push;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = add_ok ? next_slot(tail_r) : tail_r;
    walk_nxt       = walk_r;
    end_nxt        = end_r;
    delay_nxt      = cfg_wr_en ? cfg_wr_data : delay_r;
    pend_valid_nxt = pend_valid_r;
    pend_node_nxt  = pend_node_r;
    pend_frame_nxt = pend_frame_r;
    if (cmd.start) begin
      walk_nxt = head_r;
      end_nxt  = tail_r;
    end
    if (cmd.step) begin
      walk_nxt = next_slot(walk_r);
      // a finished entry retires the head, wherever the entry sits
      if (retire) begin
        head_nxt = next_slot(head_r);
      end
      if (emit) begin
        pend_valid_nxt = 1'b1;
        pend_node_nxt  = cur_node;
        pend_frame_nxt = cur_frame[OUT_FRAME_W-1:0];
      end
    end
    if (cmd.flush) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_node_nxt  = out_node_r;
    out_frame_nxt = out_frame_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_node_nxt  = pend_node_r;
      out_frame_nxt = pend_frame_r;
      out_last_nxt  = push_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      walk_r       <= '0;
      end_r        <= '0;
      delay_r      <= DELAY_RST;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      walk_r       <= walk_nxt;
      end_r        <= end_nxt;
      delay_r      <= delay_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_node_r  <= pend_node_nxt;
    pend_frame_r <= pend_frame_nxt;
    out_node_r   <= out_node_nxt;
    out_frame_r  <= out_frame_nxt;
    out_last_r   <= out_last_nxt;
  end

  // entry storage: add writes at tail, a walk step rewrites the visited entry
  always_ff @(posedge clk) begin
    if (add_ok) begin
      entry_node_r[tail_r]   <= in_node_id;
      entry_frame_r[tail_r]  <= FRAME_W'(0) - FRAME_W'(delay_r);
      entry_toggle_r[tail_r] <= 1'b0;
    end else if (cmd.step) begin
      entry_toggle_r[walk_r] <= !cur_toggle;
      if (cur_toggle) begin
        entry_frame_r[walk_r] <= inc_frame;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_id_res = out_node_r;
  assign out_frame       = out_frame_r;
  assign out_last        = out_last_r;

endmodule

### rtl/core/animation_ring_sequencer_top.sv
// ----------------------------------------------------------------------------
// animation_ring_sequencer_top
// Ring queue of animation jobs: add enqueues a node, tick walks all entries
// and emits (node, frame) for each started entry, the final one marked last.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   in       | in_valid/in_ready, in_req_type, in_node_id | input
//   out      | out_valid/out_ready, out_node_id_res,      | output
//            | out_frame, out_last                        |
//   cfg      | cfg_wr_en, cfg_wr_data (start delay)       | input
//
// An add is accepted directly from idle. A tick accepts the request, visits
// the queued entries in turn while the output allows, then ends the walk and
// flushes the held result.
// Each result waits in a one-deep hold register until the next one (or the
// end of the walk) tells whether it is last; a stalled output stops the walk.
// Reset is synchronous, active low; entry storage is not cleared.
// ----------------------------------------------------------------------------
module animation_ring_sequencer_top
  import ars_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [NODE_W-1:0]      in_node_id,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NODE_W-1:0]      out_node_id_res,
  output logic [OUT_FRAME_W-1:0] out_frame,
  output logic                   out_last,
  input  logic                   cfg_wr_en,
  input  logic [DELAY_W-1:0]     cfg_wr_data
);

  ars_cmd_t cmd;
  ars_sts_t sts;

  ars_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  ars_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_node_id      (in_node_id),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_id_res (out_node_id_res),
    .out_frame       (out_frame),
    .out_last        (out_last)
  );

  // no result may be held back once the block is ready for a new transaction
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("held result left over after walk");

  // a flush always lands a last-marked result in the output register
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_valid && out_last))
    else $error("flush did not produce last result");

  // never advance an entry whose result has nowhere to go
  a_step_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.step_ok)
    else $error("walk step while output blocked");

endmodule

### tb/sv/ars_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_draw_checker
// Tracks the animation ring from every accepted add and tick, works out the
// draws each tick must produce, and compares them in order with the out
// channel. Mismatch count and outstanding draw count go back to the top.
// ----------------------------------------------------------------------------
module ars_draw_checker
  import ars_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [NODE_W-1:0]      in_node_id,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [NODE_W-1:0]      out_node_id_res,
  input  logic [OUT_FRAME_W-1:0] out_frame,
  input  logic                   out_last,
  input  logic                   cfg_wr_en,
  input  logic [DELAY_W-1:0]     cfg_wr_data,
  output int                     mismatches,
  output int                     backlog
);

  typedef struct packed {
    logic [NODE_W-1:0]      node;
    logic [OUT_FRAME_W-1:0] frame;
    logic                   last;
  } draw_t;

  logic [NODE_W-1:0]         slot_node  [QSLOTS];
  logic signed [FRAME_W-1:0] slot_frame [QSLOTS];
  logic                      slot_half  [QSLOTS];
  logic [IDX_W-1:0]          head_q;
  logic [IDX_W-1:0]          tail_q;
  logic [DELAY_W-1:0]        delay_q;
  draw_t                     pending_draws [$];

  initial begin
    mismatches = 0;
    backlog    = 0;
  end

  task automatic flag(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_draw();
    draw_t want;
    if (pending_draws.size() == 0) begin
      flag($sformatf("unexpected draw node %0d frame %0d last %0b",
                     out_node_id_res, out_frame, out_last));
    end else begin
      want = pending_draws.pop_front();
      if (out_node_id_res !== want.node)
        flag($sformatf("node got %0d want %0d", out_node_id_res, want.node));
      if (out_frame !== want.frame)
        flag($sformatf("frame got %0d want %0d (node %0d)", out_frame, want.frame,
                       want.node));
      if (out_last !== want.last)
        flag($sformatf("last got %0b want %0b (node %0d)", out_last, want.last,
                       want.node));
    end
  endtask

  task automatic apply_request(input req_t kind, input logic [NODE_W-1:0] node);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] stop;
    draw_t            d;
    int               emitted;
    emitted = 0;
    if (kind == REQ_ADD) begin
      idx = tail_q + 1'b1;
      // drop the add when the ring already holds QSLOTS-1 entries
      if (idx != head_q) begin
        slot_node[tail_q]  = node;
        slot_frame[tail_q] = FRAME_W'(0) - FRAME_W'(delay_q);
        slot_half[tail_q]  = 1'b0;
        tail_q             = idx;
      end
    end else begin
      // walk bounds are fixed at the start even if the head moves
      idx  = head_q;
      stop = tail_q;
      while (idx != stop) begin
        if (slot_frame[idx] >= 0) begin
          d.node  = slot_node[idx];
          d.frame = slot_frame[idx][OUT_FRAME_W-1:0];
          d.last  = 1'b0;
          pending_draws.push_back(d);
          emitted++;
        end
        if (slot_half[idx]) begin
          slot_half[idx]  = 1'b0;
          slot_frame[idx] = slot_frame[idx] + FRAME_W'(1);
          // a finished entry retires the oldest one, wherever it sits
          if (slot_frame[idx] >= FRAME_COUNT) head_q = head_q + 1'b1;
        end else begin
          slot_half[idx] = 1'b1;
        end
        idx = idx + 1'b1;
      end
      if (emitted > 0) begin
        d      = pending_draws.pop_back();
        d.last = 1'b1;
        pending_draws.push_back(d);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_q  = '0;
      tail_q  = '0;
      delay_q = DELAY_RST;
      pending_draws.delete();
    end else begin
      if (out_valid && out_ready) check_draw();
      if (cfg_wr_en) delay_q = cfg_wr_data;
      if (in_valid && in_ready) apply_request(req_t'(in_req_type), in_node_id);
    end
    backlog <= pending_draws.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives adds and ticks into the animation ring sequencer under several start
// delays, with random gaps on the input and random stalls on the output.
// The draw checker beside the block predicts and compares every draw.
// ----------------------------------------------------------------------------
module tb;
  import ars_pkg::*;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_req_type = REQ_ADD;
  logic [NODE_W-1:0]      in_node_id  = '0;
  logic                   out_ready   = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [DELAY_W-1:0]     cfg_wr_data = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic [NODE_W-1:0]      out_node_id_res;
  logic [OUT_FRAME_W-1:0] out_frame;
  logic                   out_last;
  int                     mismatches;
  int                     backlog;
  int                     stall_left  = 0;
  bit                     steady      = 1'b0;

  always #6 clk = ~clk;

  animation_ring_sequencer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_id_res (out_node_id_res),
    .out_frame       (out_frame),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  ars_draw_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_id_res (out_node_id_res),
    .out_frame       (out_frame),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .backlog         (backlog)
  );

  // mostly short gaps, a few long ones, none while steady
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) steady <= !steady;
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  task automatic send_request(input req_t kind, input logic [NODE_W-1:0] node);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_node_id  <= node;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_request();
    logic [NODE_W-1:0] node;
    node = NODE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 35) send_request(REQ_ADD, node);
    else send_request(REQ_TICK, node);
  endtask

  // drain every outstanding draw, then give a silent walk time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [DELAY_W-1:0] phase_delay;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty tick, then extreme ids under the reset delay
    send_request(REQ_TICK, 8'h00);
    send_request(REQ_ADD, 8'hFF);
    send_request(REQ_ADD, 8'h00);
    send_request(REQ_TICK, 8'hFF);
    send_request(REQ_TICK, 8'h00);
    write_delay(4'd0);
    send_request(REQ_ADD, 8'h55);
    send_request(REQ_ADD, 8'hAA);
    // fill the ring; the last add finds it full and is dropped
    repeat (12) send_request(REQ_ADD, NODE_W'($urandom_range(0, 255)));
    repeat (6) send_request(REQ_TICK, 8'h00);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       phase_delay = 4'd15;
        1:       phase_delay = 4'd0;
        3:       phase_delay = DELAY_RST;
        default: phase_delay = DELAY_W'($urandom_range(1, 14));
      endcase
      write_delay(phase_delay);
      repeat (15) random_request();
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
